// File: sv/dbc_pkg.sv
// Package with constants, types and arithmetic helpers of the deadbeat current controller.
package dbc_pkg;

   localparam logic [2:0] REG_Z11  = 3'd0;
   localparam logic [2:0] REG_Z12  = 3'd1;
   localparam logic [2:0] REG_Z13  = 3'd2;
   localparam logic [2:0] REG_Z14  = 3'd3;
   localparam logic [2:0] REG_GAIN = 3'd4;
   localparam logic [2:0] REG_AMP  = 3'd5;

   localparam logic signed [31:0] K_INV_SQRT3  = 32'sd619925132;
   localparam logic signed [31:0] K_HALF_SQRT3 = 32'sd929887697;
   localparam logic signed [31:0] SIN_C1 = 32'sd1686629713;
   localparam logic signed [31:0] SIN_C3 = 32'sd693598668;
   localparam logic signed [31:0] SIN_C5 = 32'sd85569306;
   localparam logic signed [31:0] SIN_C7 = 32'sd5026994;
   localparam logic signed [31:0] SIN_C9 = 32'sd172272;
   localparam logic signed [31:0] Q30_ONE = 32'sd1073741824;

   typedef struct packed {
      logic signed [31:0] z11;
      logic signed [31:0] z12;
      logic signed [31:0] z13;
      logic signed [31:0] z14;
      logic signed [31:0] gain;
      logic [14:0]        amp;
   } cfg_type;

   // Rounds to nearest with ties away from zero, shift by n.
   function automatic logic signed [79:0] rshr(input logic signed [79:0] v, input int n);
      logic [79:0] mag;
      logic [79:0] r;
      mag = v[79] ? 80'(-v) : 80'(v);
      r = (mag + (80'd1 << (n - 1))) >> n;
      return v[79] ? -$signed(r) : $signed(r);
   endfunction

   function automatic logic signed [31:0] sat32(input logic signed [79:0] v);
      if (v > 80'sd2147483647) return 32'sh7fffffff;
      if (v < -80'sd2147483648) return 32'sh80000000;
      return v[31:0];
   endfunction

   // Rounds x * 65536 / 3 to nearest, using 65536 * m + 1 = 3 * 21845 * m + m + 1.
   function automatic logic signed [31:0] rdiv3_sat(input logic signed [31:0] x);
      logic [31:0] mag;
      logic [63:0] p;
      logic [47:0] q;
      mag = x[31] ? 32'(-x) : 32'(x);
      p = 64'(mag + 32'd1) * 64'h0000_0000_AAAA_AAAB;
      q = 48'(mag) * 48'd21845 + 48'(p[63:33]);
      return sat32(x[31] ? -$signed(80'(q)) : $signed(80'(q)));
   endfunction

endpackage

// File: sv/dbc_sine.sv
// Pipelined Q30 sine and cosine polynomial with quadrant folding.
module dbc_sine (
   input  logic               clock,
   input  logic               enable,
   input  logic [31:0]        angle,
   output logic signed [31:0] sin_q30,
   output logic signed [31:0] cos_q30
);
   localparam int NS = 7;
   logic signed [31:0] x_ff  [2][NS];
   logic signed [31:0] x2_ff [2][NS];
   logic signed [31:0] t_ff  [2][NS];
   logic               neg_ff[2][NS];
   logic [31:0]        a_in  [2];

   function automatic logic signed [31:0] Q30_ONE_f(input logic [31:0] a);
      return dbc_pkg::Q30_ONE - $signed({2'b00, a[29:0]});
   endfunction

   function automatic logic signed [31:0] clamp(input logic signed [79:0] s, input logic n);
      logic signed [31:0] c;
      if (s > 80'(dbc_pkg::Q30_ONE)) c = dbc_pkg::Q30_ONE;
      else if (s < 0) c = 32'sd0;
      else c = s[31:0];
      return n ? -c : c;
   endfunction

   assign a_in[0] = angle;
   assign a_in[1] = angle + 32'h4000_0000;

   always_ff @(posedge clock) begin
      if (enable) begin
         for (int k = 0; k < 2; k++) begin
            x_ff[k][0] <= a_in[k][30] ? Q30_ONE_f(a_in[k]) : $signed({2'b00, a_in[k][29:0]});
            neg_ff[k][0] <= a_in[k][31];
            x2_ff[k][0] <= 32'sd0;
            t_ff[k][0] <= dbc_pkg::SIN_C9;
            x2_ff[k][1] <= dbc_pkg::rshr(80'(x_ff[k][0]) * 80'(x_ff[k][0]), 30) > 0 ?
                           32'(dbc_pkg::rshr(80'(x_ff[k][0]) * 80'(x_ff[k][0]), 30)) : 32'sd0;
            x_ff[k][1] <= x_ff[k][0];
            t_ff[k][1] <= t_ff[k][0];
            neg_ff[k][1] <= neg_ff[k][0];
            x_ff[k][2] <= x_ff[k][1]; x2_ff[k][2] <= x2_ff[k][1];
            neg_ff[k][2] <= neg_ff[k][1];
            t_ff[k][2] <= 32'(80'(dbc_pkg::SIN_C7) -
                          dbc_pkg::rshr(80'(x2_ff[k][1]) * 80'(t_ff[k][1]), 30));
            x_ff[k][3] <= x_ff[k][2]; x2_ff[k][3] <= x2_ff[k][2];
            neg_ff[k][3] <= neg_ff[k][2];
            t_ff[k][3] <= 32'(80'(dbc_pkg::SIN_C5) -
                          dbc_pkg::rshr(80'(x2_ff[k][2]) * 80'(t_ff[k][2]), 30));
            x_ff[k][4] <= x_ff[k][3]; x2_ff[k][4] <= x2_ff[k][3];
            neg_ff[k][4] <= neg_ff[k][3];
            t_ff[k][4] <= 32'(80'(dbc_pkg::SIN_C3) -
                          dbc_pkg::rshr(80'(x2_ff[k][3]) * 80'(t_ff[k][3]), 30));
            x_ff[k][5] <= x_ff[k][4]; x2_ff[k][5] <= x2_ff[k][4];
            neg_ff[k][5] <= neg_ff[k][4];
            t_ff[k][5] <= 32'(80'(dbc_pkg::SIN_C1) -
                          dbc_pkg::rshr(80'(x2_ff[k][4]) * 80'(t_ff[k][4]), 30));
            x_ff[k][6] <= x_ff[k][5]; x2_ff[k][6] <= x2_ff[k][5];
            neg_ff[k][6] <= neg_ff[k][5];
            t_ff[k][6] <= clamp(dbc_pkg::rshr(80'(x_ff[k][5]) * 80'(t_ff[k][5]), 30),
                                neg_ff[k][5]);
         end
      end
   end

   assign sin_q30 = t_ff[0][NS-1];
   assign cos_q30 = t_ff[1][NS-1];
endmodule

// File: sv/dbc_law.sv
// Deadbeat law for one axis, three register stages.
module dbc_law (
   input  logic               clock,
   input  logic               enable,
   input  dbc_pkg::cfg_type   cfg,
   input  logic signed [31:0] ref_val,
   input  logic signed [31:0] il,
   input  logic signed [31:0] vc,
   input  logic signed [31:0] io,
   input  logic signed [31:0] dis,
   output logic signed [31:0] drive
);
   logic signed [79:0] p11_ff, p12_ff, p13_ff, p14_ff;
   logic signed [31:0] ref_ff, num_ff;

   always_ff @(posedge clock) begin
      if (enable) begin
         p11_ff <= dbc_pkg::rshr(80'(cfg.z11) * 80'(il), 16);
         p12_ff <= dbc_pkg::rshr(80'(cfg.z12) * 80'(vc), 16);
         p13_ff <= dbc_pkg::rshr(80'(cfg.z13) * 80'(io), 16);
         p14_ff <= dbc_pkg::rshr(80'(cfg.z14) * 80'(dis), 16);
         ref_ff <= ref_val;
         num_ff <= dbc_pkg::sat32(80'(ref_ff) - p11_ff - p12_ff - p13_ff - p14_ff);
         drive  <= dbc_pkg::sat32(dbc_pkg::rshr(80'(num_ff) * 80'(cfg.gain), 16));
      end
   end
endmodule

// File: sv/deadbeat_current_controller.sv
// Top level of the deadbeat current controller with stream ports and register port.
// Throughput: one word per cycle; the pipeline advances whenever the output stage is free.
// The sine unit's seven stages and the deadbeat law's three register stages are part of the pipeline depth.
// Reset is synchronous and active high; it clears the valid bits and loads register defaults.
module deadbeat_current_controller #(
   parameter int SAMPLE_BITS = 16,
   parameter int ANGLE_BITS  = 16
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_tvalid,
   output logic                       req_tready,
   // ind_cur_u, ind_cur_v, ind_cur_w, branch_cur_u..w, cap_volt_u..w, phase_angle
   input  logic [((9*SAMPLE_BITS+ANGLE_BITS+7)/8)*8-1:0] req_tdata,
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   // drive_u, drive_v, drive_w, drive_alpha, drive_beta, ref_alpha, ref_beta
   output logic [223:0]               rsp_tdata,
   input  logic                       csr_psel,
   input  logic                       csr_penable,
   input  logic                       csr_pwrite,
   input  logic [4:0]                 csr_paddr,
   input  logic [31:0]                csr_pwdata,
   output logic [31:0]                csr_prdata,
   output logic                       csr_pready
);
   localparam int SB = SAMPLE_BITS;
   localparam int DEPTH = 13;

   dbc_pkg::cfg_type cfg_ff;
   logic [2:0] ridx;
   assign ridx = csr_paddr[4:2];
   assign csr_pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{z11: 32'sd65536, z12: 32'sd0, z13: 32'sd0, z14: 32'sd0,
                     gain: 32'sd65536, amp: 15'd0};
      end else if (csr_psel && csr_penable && csr_pwrite) begin
         case (ridx)
            dbc_pkg::REG_Z11:  cfg_ff.z11  <= csr_pwdata;
            dbc_pkg::REG_Z12:  cfg_ff.z12  <= csr_pwdata;
            dbc_pkg::REG_Z13:  cfg_ff.z13  <= csr_pwdata;
            dbc_pkg::REG_Z14:  cfg_ff.z14  <= csr_pwdata;
            dbc_pkg::REG_GAIN: cfg_ff.gain <= csr_pwdata;
            dbc_pkg::REG_AMP:  cfg_ff.amp  <= csr_pwdata[14:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (ridx)
         dbc_pkg::REG_Z11:  csr_prdata = cfg_ff.z11;
         dbc_pkg::REG_Z12:  csr_prdata = cfg_ff.z12;
         dbc_pkg::REG_Z13:  csr_prdata = cfg_ff.z13;
         dbc_pkg::REG_Z14:  csr_prdata = cfg_ff.z14;
         dbc_pkg::REG_GAIN: csr_prdata = cfg_ff.gain;
         dbc_pkg::REG_AMP:  csr_prdata = {17'd0, cfg_ff.amp};
         default:           csr_prdata = 32'd0;
      endcase
   end

   logic [DEPTH-1:0] vld_ff;
   logic             en;
   assign en = !rsp_tvalid || rsp_tready;
   assign req_tready = en;
   assign rsp_tvalid = vld_ff[DEPTH-1];

   always_ff @(posedge clock) begin
      if (reset) vld_ff <= '0;
      else if (en) vld_ff <= {vld_ff[DEPTH-2:0], req_tvalid};
   end

   logic signed [SB-1:0] s [9];
   always_comb for (int i = 0; i < 9; i++) s[i] = req_tdata[i*SB +: SB];
   logic [31:0] ang;
   assign ang = {req_tdata[9*SB +: ANGLE_BITS], {(32-ANGLE_BITS){1'b0}}};

   // Stage 1: Clarke sums.
   logic signed [SB+2:0] ila_ff, ica_ff, vca_ff;
   logic signed [SB+1:0] ilb_ff, icb_ff, vcb_ff;
   always_ff @(posedge clock) begin
      if (en) begin
         ila_ff <= ((SB+3)'(s[0]) <<< 1) - (SB+3)'(s[1]) - (SB+3)'(s[2]);
         ica_ff <= ((SB+3)'(s[3]) <<< 1) - (SB+3)'(s[4]) - (SB+3)'(s[5]);
         vca_ff <= (SB+3)'(s[6]) - (SB+3)'(s[8]);
         ilb_ff <= (SB+2)'(s[1]) - (SB+2)'(s[2]);
         icb_ff <= (SB+2)'(s[4]) - (SB+2)'(s[5]);
         vcb_ff <= (SB+2)'(s[7]);
      end
   end

   // Stage 2: scaled Q16.16 values.
   logic signed [31:0] c_ff [6];
   always_ff @(posedge clock) begin
      if (en) begin
         c_ff[0] <= dbc_pkg::rdiv3_sat(32'(ila_ff));
         c_ff[1] <= dbc_pkg::sat32(dbc_pkg::rshr(80'(ilb_ff) * 80'(dbc_pkg::K_INV_SQRT3), 14));
         c_ff[2] <= dbc_pkg::rdiv3_sat(32'(ica_ff));
         c_ff[3] <= dbc_pkg::sat32(dbc_pkg::rshr(80'(icb_ff) * 80'(dbc_pkg::K_INV_SQRT3), 14));
         c_ff[4] <= dbc_pkg::rdiv3_sat(32'(vca_ff));
         c_ff[5] <= dbc_pkg::sat32(dbc_pkg::rshr(80'(vcb_ff) * 80'(dbc_pkg::K_INV_SQRT3), 14));
      end
   end

   // Delay line that aligns the Clarke values with the sine unit output.
   localparam int CD = 5;
   logic signed [31:0] cd_ff [CD][6];
   always_ff @(posedge clock) begin
      if (en) begin
         cd_ff[0] <= c_ff;
         for (int i = 1; i < CD; i++) cd_ff[i] <= cd_ff[i-1];
      end
   end

   logic signed [31:0] sn, cs;
   dbc_sine u_sine (.clock(clock), .enable(en), .angle(ang), .sin_q30(sn), .cos_q30(cs));

   // Stage 8: references.
   logic signed [31:0] ra_ff, rb_ff;
   logic signed [31:0] k_ff [6];
   always_ff @(posedge clock) begin
      if (en) begin
         ra_ff <= dbc_pkg::sat32(dbc_pkg::rshr(80'(cfg_ff.amp) * 80'(sn), 14));
         rb_ff <= dbc_pkg::sat32(-dbc_pkg::rshr(80'(cfg_ff.amp) * 80'(cs), 14));
         k_ff  <= cd_ff[CD-1];
      end
   end

   // Stage 9: disturbance and output current.
   logic signed [31:0] da_ff, db_ff, oa_ff, ob_ff, ra2_ff, rb2_ff;
   logic signed [31:0] ila2_ff, ilb2_ff, vca2_ff, vcb2_ff, dda, ddb;
   assign dda = dbc_pkg::sat32(80'(ra_ff) - 80'(k_ff[0]));
   assign ddb = dbc_pkg::sat32(80'(rb_ff) - 80'(k_ff[1]));
   always_ff @(posedge clock) begin
      if (en) begin
         da_ff <= dda;
         db_ff <= ddb;
         oa_ff <= dbc_pkg::sat32(80'(k_ff[0]) - 80'(k_ff[2]) + 80'(dda));
         ob_ff <= dbc_pkg::sat32(80'(k_ff[1]) - 80'(k_ff[3]) + 80'(ddb));
         ra2_ff <= ra_ff; rb2_ff <= rb_ff;
         ila2_ff <= k_ff[0]; ilb2_ff <= k_ff[1];
         vca2_ff <= k_ff[4]; vcb2_ff <= k_ff[5];
      end
   end

   logic signed [31:0] ua, ub;
   dbc_law u_law_a (.clock(clock), .enable(en), .cfg(cfg_ff), .ref_val(ra2_ff), .il(ila2_ff),
                    .vc(vca2_ff), .io(oa_ff), .dis(da_ff), .drive(ua));
   dbc_law u_law_b (.clock(clock), .enable(en), .cfg(cfg_ff), .ref_val(rb2_ff), .il(ilb2_ff),
                    .vc(vcb2_ff), .io(ob_ff), .dis(db_ff), .drive(ub));

   logic signed [31:0] rd_ff [3][2];
   always_ff @(posedge clock) begin
      if (en) begin
         rd_ff[0][0] <= ra2_ff; rd_ff[0][1] <= rb2_ff;
         rd_ff[1] <= rd_ff[0];
         rd_ff[2] <= rd_ff[1];
      end
   end

   // Stage 13: inverse Clarke and output register.
   logic signed [31:0] vv, ww;
   always_ff @(posedge clock) begin
      if (en) begin
         rsp_tdata[31:0]    <= ua;
         rsp_tdata[63:32]   <= dbc_pkg::sat32(dbc_pkg::rshr(-(80'(ua) <<< 29) +
                               80'(ub) * 80'(dbc_pkg::K_HALF_SQRT3), 30));
         rsp_tdata[95:64]   <= dbc_pkg::sat32(dbc_pkg::rshr(-(80'(ua) <<< 29) -
                               80'(ub) * 80'(dbc_pkg::K_HALF_SQRT3), 30));
         rsp_tdata[127:96]  <= ua;
         rsp_tdata[159:128] <= ub;
         rsp_tdata[191:160] <= rd_ff[2][0];
         rsp_tdata[223:192] <= rd_ff[2][1];
      end
   end
   assign vv = rsp_tdata[63:32];
   assign ww = rsp_tdata[95:64];

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("response changed during stall");
   a_ready: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |-> !req_tready)
      else $error("pipeline advanced during stall");
   a_alpha_copy: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[31:0] == rsp_tdata[127:96])
      else $error("drive_u differs from drive_alpha");
   a_sum: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[127:96] == 32'sd0 |-> (vv == -ww))
      else $error("inverse Clarke symmetry broken");
endmodule

// File: tb/tb_top.sv
// Self-checking testbench for the deadbeat current controller stream and register ports.
`timescale 1ns / 1ps

module tb_top;

   localparam int LATENCY = 13;
   localparam int CYCLE_LIMIT = 600000;
   localparam logic [2:0] REG_SPARE6 = 3'd6;
   localparam logic [2:0] REG_SPARE7 = 3'd7;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [159:0] req_tdata = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [223:0] rsp_tdata;
   logic csr_psel = 1'b0;
   logic csr_penable = 1'b0;
   logic csr_pwrite = 1'b0;
   logic [4:0] csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic csr_pready;

   longint coef_inductor, coef_capvoltage, coef_output_current, coef_disturbance;
   longint inv_input_gain, ref_amplitude;

   logic [223:0] expected_drive[$];
   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int mismatches = 0;
   longint cycles = 0;

   string field_names[7] = '{"drive_u", "drive_v", "drive_w", "drive_alpha", "drive_beta",
                             "ref_alpha", "ref_beta"};

   deadbeat_current_controller DUT (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic longint round_shift(longint v, int n);
      longint mag;
      mag = (v < 0) ? -v : v;
      mag = (mag + (64'sd1 <<< (n - 1))) >>> n;
      return (v < 0) ? -mag : mag;
   endfunction

   function automatic longint round_div3(longint v);
      if (v >= 0) return (v + 1) / 3;
      return -((-v + 1) / 3);
   endfunction

   function automatic longint clamp32(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
   endfunction

   function automatic longint sine_q30(bit [31:0] a);
      longint p, x, x2, t, s;
      p = longint'(a[29:0]);
      x = a[30] ? longint'(dbc_pkg::Q30_ONE) - p : p;
      x2 = round_shift(x * x, 30);
      t = dbc_pkg::SIN_C9;
      t = longint'(dbc_pkg::SIN_C7) - round_shift(x2 * t, 30);
      t = longint'(dbc_pkg::SIN_C5) - round_shift(x2 * t, 30);
      t = longint'(dbc_pkg::SIN_C3) - round_shift(x2 * t, 30);
      t = longint'(dbc_pkg::SIN_C1) - round_shift(x2 * t, 30);
      s = round_shift(x * t, 30);
      if (s > longint'(dbc_pkg::Q30_ONE)) s = dbc_pkg::Q30_ONE;
      if (s < 0) s = 0;
      return a[31] ? -s : s;
   endfunction

   function automatic longint deadbeat_law(longint r, longint il, longint vc, longint io,
                                           longint dis);
      longint num;
      num = r - round_shift(coef_inductor * il, 16) - round_shift(coef_capvoltage * vc, 16)
            - round_shift(coef_output_current * io, 16) - round_shift(coef_disturbance * dis, 16);
      num = clamp32(num);
      return clamp32(round_shift(num * inv_input_gain, 16));
   endfunction

   function automatic logic [223:0] predict_drive(logic [159:0] w);
      longint s[9];
      longint il_a, il_b, ic_a, ic_b, vc_a, vc_b, r_a, r_b, d_a, d_b, o_a, o_b, u_a, u_b;
      longint f[7];
      bit [31:0] ang;
      logic [223:0] r;
      for (int i = 0; i < 9; i++) s[i] = longint'($signed(w[16*i +: 16]));
      ang = {w[159:144], 16'h0000};
      il_a = clamp32(round_div3((2 * s[0] - s[1] - s[2]) * 65536));
      il_b = clamp32(round_shift((s[1] - s[2]) * longint'(dbc_pkg::K_INV_SQRT3), 14));
      ic_a = clamp32(round_div3((2 * s[3] - s[4] - s[5]) * 65536));
      ic_b = clamp32(round_shift((s[4] - s[5]) * longint'(dbc_pkg::K_INV_SQRT3), 14));
      vc_a = clamp32(round_div3((s[6] - s[8]) * 65536));
      vc_b = clamp32(round_shift(s[7] * longint'(dbc_pkg::K_INV_SQRT3), 14));
      r_a = clamp32(round_shift(ref_amplitude * sine_q30(ang), 14));
      r_b = clamp32(-round_shift(ref_amplitude * sine_q30(ang + 32'h40000000), 14));
      d_a = clamp32(r_a - il_a);
      d_b = clamp32(r_b - il_b);
      o_a = clamp32(il_a - ic_a + d_a);
      o_b = clamp32(il_b - ic_b + d_b);
      u_a = deadbeat_law(r_a, il_a, vc_a, o_a, d_a);
      u_b = deadbeat_law(r_b, il_b, vc_b, o_b, d_b);
      f[0] = u_a;
      f[1] = clamp32(round_shift(-u_a * 536870912 + u_b * longint'(dbc_pkg::K_HALF_SQRT3), 30));
      f[2] = clamp32(round_shift(-u_a * 536870912 - u_b * longint'(dbc_pkg::K_HALF_SQRT3), 30));
      f[3] = u_a;
      f[4] = u_b;
      f[5] = r_a;
      f[6] = r_b;
      for (int i = 0; i < 7; i++) r[32*i +: 32] = f[i][31:0];
      return r;
   endfunction

   always @(negedge clock) rsp_tready <= ($urandom_range(99) >= recv_idle_pct);

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   always @(posedge clock) begin
      logic [223:0] exp_word;
      bit bad;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_drive.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected response word %h", rsp_tdata);
         end else begin
            exp_word = expected_drive.pop_front();
            bad = 0;
            for (int i = 0; i < 7; i++) begin
               if (rsp_tdata[32*i +: 32] !== exp_word[32*i +: 32]) begin
                  bad = 1;
                  if (mismatches < 10)
                     $display("%s: expected %0d actual %0d", field_names[i],
                              $signed(exp_word[32*i +: 32]), $signed(rsp_tdata[32*i +: 32]));
               end
            end
            if (bad) mismatches++;
         end
      end
   end

   task automatic send_word(logic [159:0] w);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid = 1'b0;
         @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tdata = w;
      do @(posedge clock); while (!req_tready);
      expected_drive.push_back(predict_drive(w));
   endtask

   task automatic send_samples(logic [15:0] iu, iv, iw, bu, bv, bw, vu, vv, vw, ang);
      send_word({ang, vw, vv, vu, bw, bv, bu, iw, iv, iu});
   endtask

   task automatic drain;
      @(negedge clock);
      req_tvalid = 1'b0;
      while (expected_drive.size() != 0) @(posedge clock);
      repeat (LATENCY + 4) @(posedge clock);
   endtask

   task automatic csr_write(logic [2:0] idx, logic [31:0] val);
      @(negedge clock);
      csr_psel = 1'b1;
      csr_pwrite = 1'b1;
      csr_penable = 1'b0;
      csr_paddr = {idx, 2'b00};
      csr_pwdata = val;
      @(negedge clock);
      csr_penable = 1'b1;
      do @(posedge clock); while (!csr_pready);
      case (idx)
         dbc_pkg::REG_Z11:  coef_inductor = longint'($signed(val));
         dbc_pkg::REG_Z12:  coef_capvoltage = longint'($signed(val));
         dbc_pkg::REG_Z13:  coef_output_current = longint'($signed(val));
         dbc_pkg::REG_Z14:  coef_disturbance = longint'($signed(val));
         dbc_pkg::REG_GAIN: inv_input_gain = longint'($signed(val));
         dbc_pkg::REG_AMP:  ref_amplitude = longint'(val[14:0]);
         default: ;
      endcase
      @(negedge clock);
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
   endtask

   task automatic set_coefs(logic [31:0] z11, z12, z13, z14, gain, amp);
      csr_write(dbc_pkg::REG_Z11, z11);
      csr_write(dbc_pkg::REG_Z12, z12);
      csr_write(dbc_pkg::REG_Z13, z13);
      csr_write(dbc_pkg::REG_Z14, z14);
      csr_write(dbc_pkg::REG_GAIN, gain);
      csr_write(dbc_pkg::REG_AMP, amp);
   endtask

   function automatic logic [31:0] rand_coef;
      case ($urandom_range(3))
         0: return $urandom;
         1: return 32'($signed($urandom_range(262144)) - 131072);
         2: return 32'($signed($urandom_range(4096)) - 2048);
         default: return 32'($signed($urandom_range(65536)));
      endcase
   endfunction

   function automatic logic [15:0] rand_sample;
      if ($urandom_range(3) == 0) return 16'($signed($urandom_range(512)) - 256);
      return $urandom;
   endfunction

   task automatic test_reset_defaults;
      send_samples(16'd100, -16'sd50, -16'sd50, 16'd10, 16'd0, -16'sd10,
                   16'd300, 16'd200, -16'sd300, 16'd0);
      send_samples(16'h7fff, 16'h8000, 16'h8000, 16'h8000, 16'h7fff, 16'h7fff,
                   16'h7fff, 16'h7fff, 16'h8000, 16'hffff);
      drain;
   endtask

   task automatic test_directed_extremes;
      logic [15:0] angles[6] = '{16'h0000, 16'h4000, 16'h8000, 16'hc000, 16'hffff, 16'h2aab};
      set_coefs(32'h0001_0000, 32'h0000_8000, 32'hffff_c000, 32'h0000_4000,
                32'h0001_8000, 32'h0000_7fff);
      foreach (angles[i])
         send_samples(16'd1000, -16'sd500, -16'sd500, 16'd0, 16'd0, 16'd0,
                      16'd0, 16'd0, 16'd0, angles[i]);
      send_samples(16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff,
                   16'h7fff, 16'h7fff, 16'h7fff, 16'h0001);
      send_samples(16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000,
                   16'h8000, 16'h8000, 16'h8000, 16'h8001);
      send_samples(16'h7fff, 16'h8000, 16'h8000, 16'h8000, 16'h7fff, 16'h7fff,
                   16'h7fff, 16'h8000, 16'h8000, 16'h3fff);
      send_samples('0, '0, '0, '0, '0, '0, '0, '0, '0, '0);
      drain;
      // A zero inverse gain must force the drive values to zero.
      csr_write(dbc_pkg::REG_GAIN, 32'h0000_0000);
      send_samples(16'h7fff, 16'h8000, 16'h1234, 16'h0f0f, 16'hf0f0, 16'h5555,
                   16'haaaa, 16'h7fff, 16'h8000, 16'h6000);
      drain;
      // Extreme coefficients drive the datapath into saturation.
      set_coefs(32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff,
                32'h7fff_ffff, 32'hffff_ffff);
      send_samples(16'h7fff, 16'h8000, 16'h8000, 16'h8000, 16'h7fff, 16'h7fff,
                   16'h7fff, 16'h7fff, 16'h8000, 16'h4000);
      send_samples(16'h8000, 16'h7fff, 16'h7fff, 16'h7fff, 16'h8000, 16'h8000,
                   16'h8000, 16'h8000, 16'h7fff, 16'hc000);
      drain;
      csr_write(dbc_pkg::REG_GAIN, 32'h8000_0000);
      // Writes to unused addresses must leave every register unchanged.
      csr_write(REG_SPARE6, 32'hdead_0001);
      csr_write(REG_SPARE7, 32'h0bad_0002);
      send_samples(16'h0100, 16'hff00, 16'h0000, 16'h0010, 16'h0000, 16'hfff0,
                   16'h0400, 16'hfc00, 16'h0200, 16'h9000);
      send_samples(16'h7fff, 16'h0000, 16'h8000, 16'h0000, 16'h0000, 16'h0000,
                   16'h7fff, 16'h0000, 16'h8000, 16'he000);
      drain;
   endtask

   task automatic test_random_traffic(int send_pct, int recv_pct, int configs, int per_cfg);
      send_idle_pct = send_pct;
      recv_idle_pct = recv_pct;
      for (int c = 0; c < configs; c++) begin
         set_coefs(rand_coef(), rand_coef(), rand_coef(), rand_coef(), rand_coef(), $urandom);
         for (int n = 0; n < per_cfg; n++)
            send_samples(rand_sample(), rand_sample(), rand_sample(), rand_sample(),
                         rand_sample(), rand_sample(), rand_sample(), rand_sample(),
                         rand_sample(), $urandom);
         drain;
      end
   endtask

   initial begin
      coef_inductor = 65536;
      coef_capvoltage = 0;
      coef_output_current = 0;
      coef_disturbance = 0;
      inv_input_gain = 65536;
      ref_amplitude = 0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      test_reset_defaults;
      test_directed_extremes;
      test_random_traffic(8, 85, 5, 130);
      test_random_traffic(85, 8, 5, 130);
      test_random_traffic(0, 0, 5, 130);
      if (mismatches == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule

// File: sim.f
sv/dbc_pkg.sv
sv/dbc_sine.sv
sv/dbc_law.sv
sv/deadbeat_current_controller.sv
tb/tb_top.sv
